@@ src/tbc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbc_pkg
// Types and constants shared by the three-band compressor modules.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int QF = 29;
  localparam int FULL_SCALE = 4096;

  localparam logic signed [35:0] K_COMP_KNEE  = 36'sd107374182;
  localparam logic signed [35:0] K_RATIO      = 36'sd134217728;
  localparam logic signed [35:0] K_LIFT_KNEE  = 36'sd29527900;
  localparam logic signed [35:0] K_LIFT_OFS   = 36'sd9663676;
  localparam logic signed [35:0] K_LIFT_AMT   = 36'sd456340275;
  localparam logic signed [35:0] K_GAIN_MIN   = 36'sd161061274;
  localparam logic signed [35:0] K_GAIN_MAX   = 36'sd1744830464;
  localparam logic signed [35:0] K_WET_SCALE  = 36'sd418759311;
  localparam logic signed [35:0] K_SPLIT_SPAN = 36'sd45634028;
  localparam logic signed [35:0] K_HIGH_CAP   = 36'sd295279002;
  localparam logic signed [35:0] K_ENV_FLOOR  = 36'sd107374;
  localparam logic signed [35:0] K_LOW_BASE   = 36'sd3221225;
  localparam logic signed [35:0] K_HIGH_BASE  = 36'sd18790482;
  localparam logic signed [35:0] K_ATT_SPAN   = 36'sd161061274;
  localparam logic signed [35:0] K_REL_BASE   = 36'sd805306;
  localparam logic signed [35:0] K_REL_SPAN   = 36'sd18790482;
  localparam logic signed [35:0] K_GLIDE_BASE = 36'sd9663676;
  localparam logic signed [35:0] K_GLIDE_SPAN = 36'sd107374182;
  localparam logic signed [31:0] K_ENV_RESET  = 32'sd10737418;
  localparam logic signed [31:0] K_ONE        = 32'sd536870912;

  localparam logic [1:0] REG_DRY_WET = 2'd0;
  localparam logic [1:0] REG_TIME    = 2'd1;
  localparam logic [1:0] REG_LEVEL   = 2'd2;
  localparam logic [1:0] REG_SPLIT   = 2'd3;

  // datapath micro-operations, one per controller step
  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,      // capture input, fetch filter state
    OP_SS,        // t0 = s*s
    OP_LC,        // lc = base + t0*span, hc
    OP_LPF,       // lp = lp + (x-lp)*lc, write low filter
    OP_HPF,       // hp = hp + (x-hp)*hc, write high filter
    OP_ATT,
    OP_REL,
    OP_GLIDE,
    OP_BAND_SEL,  // pick band input, fetch env and gain
    OP_ENV,       // new envelope
    OP_TG_PREP,   // e, decide branch, start divider
    OP_TG_DIV,    // wait divider
    OP_TG_LIFT,   // g = 1 + lift*amt
    OP_TG_CLAMP,
    OP_GAIN,      // g = g + (tg-g)*glide
    OP_BAND_OUT,  // acc += x*g
    OP_WET,
    OP_MIX1,
    OP_MIX2,
    OP_MIX3,
    OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SS,
    ST_LC,
    ST_LPF,
    ST_HPF,
    ST_ATT,
    ST_REL,
    ST_GLIDE,
    ST_BAND_SEL,
    ST_ENV,
    ST_TG_PREP,
    ST_TG_DIV,
    ST_TG_LIFT,
    ST_TG_CLAMP,
    ST_GAIN,
    ST_BAND_OUT,
    ST_WET,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_OUT,
    ST_HOLD
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] band;
    logic       div_start;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_used;   // target gain took the upward lift branch
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'sh7fffffff;
    if (v < -72'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

@@ src/tbc_div.sv @@
// ----------------------------------------------------------------------------
// tbc_div
// Restoring divider, one quotient bit a cycle: q = round(num*2^29 / den).
// ----------------------------------------------------------------------------
module tbc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] num,
  input  logic [33:0] den,
  output logic        busy,
  output logic [33:0] quo
);
  localparam int NB = 64;

  logic [NB-1:0] dividend;
  logic [NB-1:0] rem;
  logic [NB-1:0] q;
  logic [33:0]   dv;
  logic [6:0]    cnt;
  logic [NB-1:0] trial;

  assign trial = {rem[NB-2:0], dividend[NB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'(NB);
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // num*2^29 + den/2 as the dividend
      dividend <= ({30'd0, num} << 29) + {31'd0, den[33:1]};
      rem      <= '0;
      q        <= '0;
      dv       <= den;
    end else if (busy) begin
      dividend <= {dividend[NB-2:0], 1'b0};
      if (trial >= {30'd0, dv}) begin
        rem <= trial - {30'd0, dv};
        q   <= {q[NB-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NB-2:0], 1'b0};
      end
    end
  end

  assign quo = q[33:0];
endmodule

@@ src/tbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbc_ctrl
// Sequencer: steps the datapath through filters, three bands and the mix.
// ----------------------------------------------------------------------------
module tbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tbc_pkg::cmd_t     cmd,
  input  tbc_pkg::status_t  status
);
  import tbc_pkg::*;

  state_t     state, state_next;
  logic [1:0] band, band_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      band  <= '0;
    end else begin
      state <= state_next;
      band  <= band_next;
    end
  end

  always_comb begin
    state_next = state;
    band_next  = band;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_SS;
      ST_SS:       state_next = ST_LC;
      ST_LC:       state_next = ST_LPF;
      ST_LPF:      state_next = ST_HPF;
      ST_HPF:      state_next = ST_ATT;
      ST_ATT:      state_next = ST_REL;
      ST_REL:      state_next = ST_GLIDE;
      ST_GLIDE:    begin
        state_next = ST_BAND_SEL;
        band_next  = 2'd0;
      end
      ST_BAND_SEL: state_next = ST_ENV;
      ST_ENV:      state_next = ST_TG_PREP;
      ST_TG_PREP:  state_next = ST_TG_DIV;
      ST_TG_DIV:   if (!status.div_busy) begin
        state_next = status.div_used ? ST_TG_LIFT : ST_TG_CLAMP;
      end
      ST_TG_LIFT:  state_next = ST_TG_CLAMP;
      ST_TG_CLAMP: state_next = ST_GAIN;
      ST_GAIN:     state_next = ST_BAND_OUT;
      ST_BAND_OUT: begin
        if (band == 2'd2) begin
          state_next = ST_WET;
        end else begin
          band_next  = band + 2'd1;
          state_next = ST_BAND_SEL;
        end
      end
      ST_WET:      state_next = ST_MIX1;
      ST_MIX1:     state_next = ST_MIX2;
      ST_MIX2:     state_next = ST_MIX3;
      ST_MIX3:     state_next = ST_OUT;
      ST_OUT:      state_next = ST_HOLD;
      ST_HOLD:     if (out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NOP;
    cmd.band      = band;
    cmd.div_start = 1'b0;
    in_ready      = (state == ST_IDLE);
    out_valid     = (state == ST_HOLD);
    unique case (state)
      // capture the item at the edge that accepts it
      ST_IDLE:     if (in_valid) cmd.op = OP_LOAD;
      ST_SS:       cmd.op = OP_SS;
      ST_LC:       cmd.op = OP_LC;
      ST_LPF:      cmd.op = OP_LPF;
      ST_HPF:      cmd.op = OP_HPF;
      ST_ATT:      cmd.op = OP_ATT;
      ST_REL:      cmd.op = OP_REL;
      ST_GLIDE:    cmd.op = OP_GLIDE;
      ST_BAND_SEL: cmd.op = OP_BAND_SEL;
      ST_ENV:      cmd.op = OP_ENV;
      ST_TG_PREP:  begin
        cmd.op        = OP_TG_PREP;
        cmd.div_start = 1'b1;
      end
      ST_TG_DIV:   cmd.op = OP_TG_DIV;
      ST_TG_LIFT:  cmd.op = OP_TG_LIFT;
      ST_TG_CLAMP: cmd.op = OP_TG_CLAMP;
      ST_GAIN:     cmd.op = OP_GAIN;
      ST_BAND_OUT: cmd.op = OP_BAND_OUT;
      ST_WET:      cmd.op = OP_WET;
      ST_MIX1:     cmd.op = OP_MIX1;
      ST_MIX2:     cmd.op = OP_MIX2;
      ST_MIX3:     cmd.op = OP_MIX3;
      ST_OUT:      cmd.op = OP_OUT;
      default:     cmd.op = OP_NOP;
    endcase
  end
endmodule

@@ src/tbc_dp.sv @@
// ----------------------------------------------------------------------------
// tbc_dp
// Datapath: state registers, one shared Q29 multiplier and the divider.
// ----------------------------------------------------------------------------
module tbc_dp #(
  parameter int SAMPLE_BITS = 24,
  parameter int CHANNELS    = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tbc_pkg::cmd_t                 cmd,
  output tbc_pkg::status_t              status,
  input  logic                          in_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [12:0]                   dry_wet,
  input  logic [12:0]                   time_setting,
  input  logic [12:0]                   output_level,
  input  logic [12:0]                   split_setting,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);
  import tbc_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BW = $clog2(3 * CHANNELS);
  localparam int FB = SAMPLE_BITS - 1;

  logic signed [31:0] low_split_filter [CHANNELS];
  logic signed [31:0] high_split_filter[CHANNELS];
  logic signed [31:0] band_envelope    [3*CHANNELS];
  logic signed [31:0] band_gain        [3*CHANNELS];

  logic [CW-1:0]      ch;
  logic signed [35:0] x, lp, hp, lc, hc, att, rel, glide;
  logic signed [35:0] bx, env, gn, tg, e, acc, t0;
  logic signed [47:0] mixr;
  logic               div_used;
  logic [BW-1:0]      bidx;

  // shared multiplier, operands chosen per step
  logic signed [35:0] ma, mb;
  logic signed [71:0] prod, qm;
  assign prod = ma * mb;
  assign qm   = (prod + (72'sd1 <<< 28)) >>> 29;

  logic        div_start, div_busy;
  logic [33:0] dnum, dden, dquo;
  tbc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(dden),
    .busy(div_busy), .quo(dquo)
  );

  // start is registered, so num and den are already registered when it arrives
  always_ff @(posedge clk) begin
    if (rst) div_start <= 1'b0;
    else div_start <= cmd.div_start;
  end
  assign status.div_busy = div_busy | div_start;
  assign status.div_used = div_used;

  function automatic logic signed [35:0] regv(input logic [12:0] r);
    return (r > 13'd4096) ? 36'sd4096 : 36'($signed({1'b0, r}));
  endfunction

  logic signed [35:0] s_q, tinv, absx, ce;
  logic signed [35:0] x_in;
  logic [CW-1:0]      ch_in;
  assign s_q  = regv(split_setting) <<< 17;
  assign tinv = K_ONE - (regv(time_setting) <<< 17);
  assign absx = bx[35] ? -bx : bx;
  assign ce   = (absx > env) ? att : rel;
  assign bidx = BW'(ch * 3 + cmd.band);

  always_comb begin
    if (FB <= QF) x_in = 36'(in_sample) <<< (QF - FB);
    else x_in = 36'(in_sample >>> (FB - QF));
    if (32'(in_channel) >= CHANNELS) ch_in = CW'(CHANNELS - 1);
    else ch_in = CW'(in_channel);
  end

  logic signed [35:0] e_c, comp;
  assign e_c  = 36'(env) + K_ENV_FLOOR;
  assign comp = K_COMP_KNEE + qm[35:0];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_SS:       begin ma = s_q;        mb = s_q;          end
      OP_LC:       begin ma = t0;         mb = K_SPLIT_SPAN; end
      OP_LPF:      begin ma = x - lp;     mb = lc;           end
      OP_HPF:      begin ma = x - hp;     mb = hc;           end
      OP_ATT:      begin ma = tinv;       mb = K_ATT_SPAN;   end
      OP_REL:      begin ma = tinv;       mb = K_REL_SPAN;   end
      OP_GLIDE:    begin ma = tinv;       mb = K_GLIDE_SPAN; end
      OP_ENV:      begin ma = absx - env; mb = ce;           end
      OP_TG_PREP:  begin ma = e_c - K_COMP_KNEE; mb = K_RATIO; end
      OP_TG_LIFT:  begin ma = 36'($signed({2'b0, dquo})); mb = K_LIFT_AMT; end
      OP_GAIN:     begin ma = tg - gn;    mb = glide;        end
      OP_BAND_OUT: begin ma = bx;         mb = gn;           end
      OP_WET:      begin ma = acc;        mb = K_WET_SCALE;  end
      default:     begin ma = '0;         mb = '0;           end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        low_split_filter[i]  <= '0;
        high_split_filter[i] <= '0;
      end
      for (int i = 0; i < 3 * CHANNELS; i++) begin
        band_envelope[i] <= K_ENV_RESET;
        band_gain[i]     <= K_ONE;
      end
      div_used <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          ch  <= ch_in;
          x   <= x_in;
          lp  <= 36'(low_split_filter[ch_in]);
          hp  <= 36'(high_split_filter[ch_in]);
          acc <= '0;
        end
        OP_SS: t0 <= qm[35:0];
        OP_LC: begin
          lc <= K_LOW_BASE + qm[35:0];
          hc <= ((K_LOW_BASE + qm[35:0]) * 8 + K_HIGH_BASE > K_HIGH_CAP) ? K_HIGH_CAP
                : (K_LOW_BASE + qm[35:0]) * 8 + K_HIGH_BASE;
        end
        OP_LPF: begin
          lp <= 36'(sat32(72'(lp) + qm));
          low_split_filter[ch] <= sat32(72'(lp) + qm);
        end
        OP_HPF: begin
          hp <= 36'(sat32(72'(hp) + qm));
          high_split_filter[ch] <= sat32(72'(hp) + qm);
        end
        OP_ATT:   att   <= K_HIGH_BASE  + qm[35:0];
        OP_REL:   rel   <= K_REL_BASE   + qm[35:0];
        OP_GLIDE: glide <= K_GLIDE_BASE + qm[35:0];
        OP_BAND_SEL: begin
          unique case (cmd.band)
            2'd0:    bx <= lp;
            2'd1:    bx <= hp - lp;
            default: bx <= x - hp;
          endcase
          env <= 36'(band_envelope[bidx]);
          gn  <= 36'(band_gain[bidx]);
        end
        OP_ENV: begin
          env <= 36'(sat32(72'(env) + qm));
          band_envelope[bidx] <= sat32(72'(env) + qm);
        end
        OP_TG_PREP: begin
          e        <= e_c;
          div_used <= 1'b0;
          tg       <= 36'(K_ONE);
          dnum     <= '0;
          dden     <= 34'd1;
          if (e_c > K_COMP_KNEE) begin
            dnum <= comp[33:0];
            dden <= e_c[33:0];
          end else if (e_c < K_LIFT_KNEE) begin
            div_used <= 1'b1;
            if (e_c + K_LIFT_OFS > 0) begin
              dnum <= 34'(K_LIFT_KNEE - e_c);
              dden <= 34'(e_c + K_LIFT_OFS);
            end else begin
              dnum <= '0;
            end
          end
        end
        OP_TG_DIV: begin
          if (!div_busy && !div_start && e > K_COMP_KNEE) tg <= 36'($signed({2'b0, dquo}));
        end
        OP_TG_LIFT: tg <= 36'(K_ONE) + qm[35:0];
        OP_TG_CLAMP: begin
          if (tg < K_GAIN_MIN) tg <= K_GAIN_MIN;
          else if (tg > K_GAIN_MAX) tg <= K_GAIN_MAX;
        end
        OP_GAIN: begin
          gn <= 36'(sat32(72'(gn) + qm));
          band_gain[bidx] <= sat32(72'(gn) + qm);
        end
        OP_BAND_OUT: acc <= acc + qm[35:0];
        OP_WET:      acc <= qm[35:0];
        OP_MIX1: mixr <= 48'(x) * 48'(36'sd4096 - regv(dry_wet));
        OP_MIX2: mixr <= (mixr + 48'(acc) * 48'(regv(dry_wet)) + 48'sd2048) >>> 12;
        OP_MIX3: mixr <= (mixr * 48'(regv(output_level)) + 48'sd1024) >>> 11;
        OP_OUT: begin
          if (FB <= QF) begin
            if (QF - FB > 0) mixr <= (mixr + (48'sd1 <<< (QF - FB - 1))) >>> (QF - FB);
          end else begin
            mixr <= mixr <<< (FB - QF);
          end
        end
        default: ;
      endcase
    end
  end

  localparam logic signed [47:0] LIM = 48'sd1 <<< FB;
  always_comb begin
    if (mixr > LIM - 48'sd1) sample_out = SAMPLE_BITS'(LIM - 48'sd1);
    else if (mixr < -LIM) sample_out = SAMPLE_BITS'(-LIM);
    else sample_out = mixr[SAMPLE_BITS-1:0];
  end
endmodule

@@ src/three_band_upward_downward_compressor_top.sv @@
// ----------------------------------------------------------------------------
// three_band_upward_downward_compressor_top
// Three-band upward/downward compressor with an APB register port.
// ----------------------------------------------------------------------------
// One item at a time: each sample passes through the shared multiplier sequence
// (7 setup steps, 5 mix steps) and three band passes, each of which waits on
// the restoring divider plus its start and hand-off, with an extra lift step
// for a band that takes the upward lift; the result is held on m_axis until
// taken, and the next item can be accepted in the cycle after that.
module three_band_upward_downward_compressor_top #(
  parameter int SAMPLE_BITS = 24,
  parameter int CHANNELS    = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_in
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // channel
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sample_out
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tbc_pkg::*;

  localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [12:0] dry_wet, time_setting, output_level, split_setting;
  logic [1:0]  ridx;
  assign ridx   = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_wet       <= 13'd4096;
      time_setting  <= 13'd2048;
      output_level  <= 13'd2048;
      split_setting <= 13'd2048;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_DRY_WET: dry_wet       <= pwdata[12:0];
        REG_TIME:    time_setting  <= pwdata[12:0];
        REG_LEVEL:   output_level  <= pwdata[12:0];
        default:     split_setting <= pwdata[12:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_DRY_WET: prdata = {19'd0, dry_wet};
      REG_TIME:    prdata = {19'd0, time_setting};
      REG_LEVEL:   prdata = {19'd0, output_level};
      default:     prdata = {19'd0, split_setting};
    endcase
  end

  cmd_t    cmd;
  status_t status;
  logic signed [SAMPLE_BITS-1:0] y;

  tbc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cmd(cmd), .status(status)
  );

  tbc_dp #(.SAMPLE_BITS(SAMPLE_BITS), .CHANNELS(CHANNELS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_channel(s_axis_tuser), .in_sample(s_axis_tdata[SAMPLE_BITS-1:0]),
    .dry_wet(dry_wet), .time_setting(time_setting), .output_level(output_level),
    .split_setting(split_setting), .sample_out(y)
  );

  assign m_axis_tdata = DW'($unsigned(y));
endmodule

@@ dv/tb_three_band_upward_downward_compressor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_band_upward_downward_compressor_top
// Streams stereo samples through the three-band compressor, predicts every
// output sample with a local fixed-point model and compares it on m_axis.
// ----------------------------------------------------------------------------
module tb_three_band_upward_downward_compressor_top;
  import tbc_pkg::*;

  localparam int SB = 24;
  localparam int CH = 2;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  three_band_upward_downward_compressor_top #(.SAMPLE_BITS(SB), .CHANNELS(CH)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic        channel;
    logic [23:0] sample_in;
  } sample_item_t;

  // predictor state
  longint unsigned wet_share, time_set, out_level, split_set;
  longint lp_state [CH];
  longint hp_state [CH];
  longint env_state [3*CH];
  longint gain_state [3*CH];

  sample_item_t   pending_samples[$];
  logic [23:0]    expected_samples[$];
  int             error_count;
  bit             stim_done;
  bit             hold_sender;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return shr(a * b + (64'sd1 <<< 28), 29);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fxdiv(longint num, longint den);
    return (num * (64'sd1 <<< 29) + den / 2) / den;
  endfunction

  function automatic longint clamp_reg(longint unsigned r);
    return (r > 4096) ? 4096 : longint'(r);
  endfunction

  function automatic longint gain_target(longint env);
    longint e, g, d, lift;
    e = env + longint'(K_ENV_FLOOR);
    g = 64'sd1 <<< 29;
    if (e > longint'(K_COMP_KNEE)) begin
      g = fxdiv(longint'(K_COMP_KNEE) + fxmul(e - longint'(K_COMP_KNEE), longint'(K_RATIO)), e);
    end else if (e < longint'(K_LIFT_KNEE)) begin
      d = e + longint'(K_LIFT_OFS);
      lift = (d > 0) ? fxdiv(longint'(K_LIFT_KNEE) - e, d) : 0;
      g = (64'sd1 <<< 29) + fxmul(lift, longint'(K_LIFT_AMT));
    end
    if (g < longint'(K_GAIN_MIN)) g = longint'(K_GAIN_MIN);
    if (g > longint'(K_GAIN_MAX)) g = longint'(K_GAIN_MAX);
    return g;
  endfunction

  function automatic longint compress_band(longint x, int idx, longint att, longint rel,
                                           longint glide);
    longint env, a, c, g;
    env = env_state[idx];
    a = (x < 0) ? -x : x;
    c = (a > env) ? att : rel;
    env_state[idx] = clip32(env + fxmul(a - env, c));
    g = gain_state[idx];
    g = g + fxmul(gain_target(env_state[idx]) - g, glide);
    gain_state[idx] = clip32(g);
    return fxmul(x, gain_state[idx]);
  endfunction

  function automatic logic [23:0] compress_sample(sample_item_t it);
    int ch;
    longint x, s, tinv, lc, hc, lp, hp, att, rel, glide, wet, mix, y;
    ch = it.channel;
    x = longint'($signed(it.sample_in)) * 64;
    s = clamp_reg(split_set) <<< 17;
    tinv = (64'sd1 <<< 29) - (clamp_reg(time_set) <<< 17);
    lc = longint'(K_LOW_BASE) + fxmul(fxmul(s, s), longint'(K_SPLIT_SPAN));
    hc = lc * 8 + longint'(K_HIGH_BASE);
    if (hc > longint'(K_HIGH_CAP)) hc = longint'(K_HIGH_CAP);
    lp = lp_state[ch];
    hp = hp_state[ch];
    lp_state[ch] = clip32(lp + fxmul(x - lp, lc));
    hp_state[ch] = clip32(hp + fxmul(x - hp, hc));
    lp = lp_state[ch];
    hp = hp_state[ch];
    att = longint'(K_HIGH_BASE) + fxmul(tinv, longint'(K_ATT_SPAN));
    rel = longint'(K_REL_BASE) + fxmul(tinv, longint'(K_REL_SPAN));
    glide = longint'(K_GLIDE_BASE) + fxmul(tinv, longint'(K_GLIDE_SPAN));
    wet = compress_band(lp, ch*3, att, rel, glide);
    wet += compress_band(hp - lp, ch*3+1, att, rel, glide);
    wet += compress_band(x - hp, ch*3+2, att, rel, glide);
    wet = fxmul(wet, longint'(K_WET_SCALE));
    mix = shr(x * (4096 - clamp_reg(wet_share)) + wet * clamp_reg(wet_share) + 2048, 12);
    mix = shr(mix * clamp_reg(out_level) + 1024, 11);
    y = shr(mix + 32, 6);
    if (y > 64'sd8388607) y = 64'sd8388607;
    if (y < -64'sd8388608) y = -64'sd8388608;
    return y[23:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: bursts with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_samples.push_back(compress_sample(pending_samples.pop_front()));
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) gap_left--;
        if (pending_samples.size() > 0 && gap_left == 0 && !hold_sender) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_samples[0].sample_in;
          s_axis_tuser  <= pending_samples[0].channel;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus checks
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_phase = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: unexpected item, actual %0d", $signed(m_axis_tdata));
          error_count++;
        end else begin
          logic [23:0] want;
          want = expected_samples.pop_front();
          if (want !== m_axis_tdata) begin
            $error("sample_out: expected %0d actual %0d", $signed(want),
                   $signed(m_axis_tdata));
            error_count++;
          end
        end
      end
      stall_phase = (stall_phase + 1) % 1024;
      if (stall_phase < 300) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DRY_WET: wet_share = val & 32'h1fff;
      REG_TIME:    time_set  = val & 32'h1fff;
      REG_LEVEL:   out_level = val & 32'h1fff;
      default:     split_set = val & 32'h1fff;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || expected_samples.size() > 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic void queue_sample(logic ch, logic [23:0] v);
    sample_item_t it;
    it.channel = ch;
    it.sample_in = v;
    pending_samples.push_back(it);
  endfunction

  function automatic logic [23:0] random_audio();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return 24'($urandom());
    if (kind == 1) return ($urandom_range(0, 1) != 0) ? 24'h7fffff : 24'h800000;
    if (kind < 5) return 24'($signed($urandom_range(0, 60000)) - 30000);
    return 24'($signed(int'($urandom_range(0, 3000000))) - 1500000);
  endfunction

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    error_count = 0; stim_done = 0; hold_sender = 0;
    wet_share = 4096; time_set = 2048; out_level = 2048; split_set = 2048;
    for (int i = 0; i < CH; i++) begin
      lp_state[i] = 0; hp_state[i] = 0;
    end
    for (int i = 0; i < 3*CH; i++) begin
      env_state[i] = longint'(K_ENV_RESET); gain_state[i] = 64'sd1 <<< 29;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, silence, both channels
    queue_sample(0, 24'h7fffff); queue_sample(1, 24'h800000);
    queue_sample(0, 24'h800000); queue_sample(1, 24'h7fffff);
    queue_sample(0, 24'h000000); queue_sample(1, 24'h000001);
    queue_sample(0, 24'hffffff); queue_sample(1, 24'h555555);
    queue_sample(0, 24'haaaaaa);
    for (int i = 0; i < 8; i++) queue_sample(i[0], 24'h000010);
    wait_drained();

    // settings sweep, extremes and over-range values included
    for (int ph = 0; ph < 8; ph++) begin
      logic [31:0] r[4];
      for (int k = 0; k < 4; k++) begin
        case (ph)
          0: r[k] = 0;
          1: r[k] = 4096;
          2: r[k] = 8191;
          3: r[k] = 32'hffffe000 | $urandom_range(0, 8191);
          default: r[k] = $urandom_range(0, 4096);
        endcase
      end
      apb_write(REG_DRY_WET, r[0]);
      apb_write(REG_TIME, r[1]);
      apb_write(REG_LEVEL, r[2]);
      apb_write(REG_SPLIT, r[3]);
      for (int i = 0; i < 135; i++) queue_sample(1'($urandom_range(0, 1)), random_audio());
      if (ph == 5) begin
        hold_sender = 1;
        while (expected_samples.size() > 0 || s_axis_tvalid) @(posedge clk);
        hold_sender = 0;
      end
      wait_drained();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (error_count == 0) $display("tb_three_band_upward_downward_compressor_top: done, clean");
    else $display("tb_three_band_upward_downward_compressor_top: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_three_band_upward_downward_compressor_top: done, errors");
    $finish;
  end

endmodule
